[rtl/dbd_pkg.sv]
// Shared types and constants of the detection box decoder.
package dbd_pkg;

  localparam int VALUE_W = 32;
  localparam int CLASS_W = 10;
  localparam int THR_W = 17;
  localparam int IMG_W = 13;
  localparam int COUNT_W = 11;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 17;
  localparam int PIX_W = 16;

  // Row layout: four geometry values, then an optional objectness value.
  localparam int GEO_COUNT = 4;
  localparam int CLASS_START_OBJ = 5;
  localparam int CLASS_START_NOOBJ = 4;

  localparam logic [THR_W-1:0] THR_RESET = 17'd16384;
  localparam logic [IMG_W-1:0] IMG_W_RESET = 13'd640;
  localparam logic [IMG_W-1:0] IMG_H_RESET = 13'd640;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd80;

  typedef enum logic [CFG_AW-1:0] {
    REG_MODE   = 3'd0,
    REG_SCALED = 3'd1,
    REG_THR    = 3'd2,
    REG_IMG_W  = 3'd3,
    REG_IMG_H  = 3'd4,
    REG_COUNT  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic               mode;
    logic               scaled;
    logic [THR_W-1:0]   thr;
    logic [IMG_W-1:0]   img_w;
    logic [IMG_W-1:0]   img_h;
    logic [COUNT_W-1:0] count;
  } cfg_t;

  // One finished row handed from the front to the back.
  typedef struct packed {
    logic [VALUE_W-1:0] gx;
    logic [VALUE_W-1:0] gy;
    logic [VALUE_W-1:0] gw;
    logic [VALUE_W-1:0] gh;
    logic [VALUE_W-1:0] obj;
    logic [VALUE_W-1:0] best;
    logic [CLASS_W-1:0] cls;
  } desc_t;

  typedef struct packed {
    logic [PIX_W-1:0]   left;
    logic [PIX_W-1:0]   top;
    logic [PIX_W-1:0]   bw;
    logic [PIX_W-1:0]   bh;
    logic [VALUE_W-1:0] conf;
    logic [CLASS_W-1:0] cls;
  } res_t;

endpackage

[rtl/dbd_fifo.sv]
// Small register FIFO used between the decoder stages.
module dbd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

[rtl/dbd_front.sv]
// Row tracker: stores geometry and objectness, keeps the best class score per row.
module dbd_front #(
  parameter int MAX_CLASSES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dbd_pkg::cfg_t                 cfg_i,
  input  logic                          push_i,
  input  logic [dbd_pkg::VALUE_W-1:0]   value_i,
  output logic                          full_o,
  input  logic                          dq_full_i,
  output logic                          dq_push_o,
  output dbd_pkg::desc_t                dq_data_o
);

  localparam int PW = $clog2(MAX_CLASSES + dbd_pkg::CLASS_START_OBJ);
  localparam int CW = $clog2(MAX_CLASSES + 1);

  logic [PW-1:0] pos_q, pos_d;
  logic          seen_q, seen_d;
  logic [dbd_pkg::VALUE_W-1:0] geo_q [dbd_pkg::GEO_COUNT];
  logic [dbd_pkg::VALUE_W-1:0] obj_q, best_q, best_d;
  logic [dbd_pkg::CLASS_W-1:0] cls_q, cls_d;

  logic [CW-1:0] count;
  logic [PW-1:0] start, last, idx;
  logic          row_end, take, is_geo, is_obj, upd;

  always_comb begin
    if (cfg_i.count == '0) begin
      count = CW'(1);
    end else if (int'(cfg_i.count) > MAX_CLASSES) begin
      count = CW'(MAX_CLASSES);
    end else begin
      count = CW'(cfg_i.count);
    end
  end

  assign start   = cfg_i.mode ? PW'(dbd_pkg::CLASS_START_NOOBJ)
                              : PW'(dbd_pkg::CLASS_START_OBJ);
  assign last    = start + PW'(count) - PW'(1);
  assign row_end = (pos_q >= last);
  assign is_geo  = (pos_q < PW'(dbd_pkg::GEO_COUNT));
  assign is_obj  = !is_geo && (pos_q < start);
  assign full_o  = row_end && dq_full_i;
  assign take    = push_i && !full_o;
  assign idx     = pos_q - start;

  // The first class score of a row always starts the maximum; ties keep the earlier one.
  assign upd = !seen_q || ($signed(value_i) > $signed(best_q));

  always_comb begin
    pos_d  = pos_q;
    seen_d = seen_q;
    best_d = best_q;
    cls_d  = cls_q;
    if (take) begin
      if (is_geo || is_obj) begin
        pos_d = pos_q + PW'(1);
      end else begin
        if (upd) begin
          best_d = value_i;
          cls_d  = dbd_pkg::CLASS_W'(idx);
        end
        if (row_end) begin
          pos_d  = '0;
          seen_d = 1'b0;
        end else begin
          pos_d  = pos_q + PW'(1);
          seen_d = 1'b1;
        end
      end
    end
  end

  assign dq_push_o = take && !is_geo && !is_obj && row_end;

  always_comb begin
    dq_data_o.gx   = geo_q[0];
    dq_data_o.gy   = geo_q[1];
    dq_data_o.gw   = geo_q[2];
    dq_data_o.gh   = geo_q[3];
    dq_data_o.obj  = obj_q;
    dq_data_o.best = best_d;
    dq_data_o.cls  = cls_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      seen_q <= 1'b0;
      cls_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      seen_q <= seen_d;
      cls_q  <= cls_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    if (take && is_geo) begin
      geo_q[pos_q[1:0]] <= value_i;
    end
    if (take && is_obj) begin
      obj_q <= value_i;
    end
  end

endmodule

[rtl/dbd_back.sv]
// Box builder: score product, threshold test, coordinate scaling and saturation.
module dbd_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dbd_pkg::cfg_t  cfg_i,
  input  logic           dq_empty_i,
  input  dbd_pkg::desc_t dq_data_i,
  output logic           dq_pop_o,
  input  logic           of_full_i,
  output logic           of_push_o,
  output dbd_pkg::res_t  of_data_o
);

  localparam int VW  = dbd_pkg::VALUE_W;
  localparam int MW  = dbd_pkg::IMG_W + 1;
  localparam int PRW = VW + MW;
  localparam int DW  = PRW + 2;
  localparam int SW  = 2 * VW;
  localparam int PXW = dbd_pkg::PIX_W;
  localparam logic [PRW-1:0] RND = PRW'((64'd1 << FRAC_BITS) - 64'd1);

  logic adv;

  // Stage 1: products.
  logic                  s1_valid_q;
  logic signed [PRW-1:0] s1_px_q, s1_py_q, s1_pw_q, s1_ph_q;
  logic signed [SW-1:0]  s1_score_q;
  logic [VW-1:0]         s1_best_q;
  logic [dbd_pkg::CLASS_W-1:0] s1_cls_q;
  logic signed [MW-1:0]  mw, mh;

  // Stage 2: edge differences, size terms, threshold decision.
  logic                  s2_valid_q, s2_pass_q, s2_limw_q, s2_limh_q;
  logic signed [DW-1:0]  s2_dx_q, s2_dy_q;
  logic signed [PRW-1:0] s2_tw_q, s2_th_q;
  logic signed [SW-1:0]  s2_conf_q;
  logic [dbd_pkg::CLASS_W-1:0] s2_cls_q;
  logic signed [DW-1:0]  dx_d, dy_d, limx, limy;
  logic signed [PRW-1:0] tw_d, th_d;
  logic signed [SW-1:0]  conf_d;
  logic                  pass_d;

  // Stage 3: saturated result.
  logic                  s3_valid_q, s3_pass_q;
  dbd_pkg::res_t         s3_res_q, res_d;
  logic signed [DW-1:0]  ex, ey;

  assign adv       = !s3_valid_q || !s3_pass_q || !of_full_i;
  assign dq_pop_o  = adv && !dq_empty_i;
  assign of_push_o = s3_valid_q && s3_pass_q;
  assign of_data_o = s3_res_q;

  assign mw = cfg_i.scaled ? MW'(1) : $signed({1'b0, cfg_i.img_w});
  assign mh = cfg_i.scaled ? MW'(1) : $signed({1'b0, cfg_i.img_h});

  always_comb begin
    dx_d = ($signed(DW'(s1_px_q)) <<< 1) - DW'(s1_pw_q);
    dy_d = ($signed(DW'(s1_py_q)) <<< 1) - DW'(s1_ph_q);
    limx = $signed(DW'(cfg_i.img_w) << FRAC_BITS);
    limy = $signed(DW'(cfg_i.img_h) << FRAC_BITS);
    // Truncation toward zero: bias negative values before the arithmetic shift.
    tw_d = $signed(s1_pw_q + $signed(s1_pw_q[PRW-1] ? RND : '0)) >>> FRAC_BITS;
    th_d = $signed(s1_ph_q + $signed(s1_ph_q[PRW-1] ? RND : '0)) >>> FRAC_BITS;
    if (!cfg_i.mode) begin
      pass_d = s1_score_q > $signed(SW'(cfg_i.thr) << FRAC_BITS);
      conf_d = s1_score_q >>> FRAC_BITS;
    end else begin
      pass_d = $signed(s1_best_q) > $signed(VW'(cfg_i.thr));
      conf_d = SW'($signed(s1_best_q));
    end
  end

  always_comb begin
    ex = s2_dx_q >>> (FRAC_BITS + 1);
    ey = s2_dy_q >>> (FRAC_BITS + 1);
    if (s2_dx_q <= 0) begin
      res_d.left = '0;
    end else if (ex > DW'(65535)) begin
      res_d.left = '1;
    end else begin
      res_d.left = ex[PXW-1:0];
    end
    if (s2_dy_q <= 0) begin
      res_d.top = '0;
    end else if (ey > DW'(65535)) begin
      res_d.top = '1;
    end else begin
      res_d.top = ey[PXW-1:0];
    end
    if (s2_limw_q) begin
      res_d.bw = PXW'(cfg_i.img_w);
    end else if (s2_tw_q < -32'sd32768) begin
      res_d.bw = 16'h8000;
    end else begin
      res_d.bw = s2_tw_q[PXW-1:0];
    end
    if (s2_limh_q) begin
      res_d.bh = PXW'(cfg_i.img_h);
    end else if (s2_th_q < -32'sd32768) begin
      res_d.bh = 16'h8000;
    end else begin
      res_d.bh = s2_th_q[PXW-1:0];
    end
    if (s2_conf_q > $signed(SW'(32'h7fff_ffff))) begin
      res_d.conf = 32'h7fff_ffff;
    end else if (s2_conf_q < -64'sd2147483648) begin
      res_d.conf = 32'h8000_0000;
    end else begin
      res_d.conf = s2_conf_q[VW-1:0];
    end
    res_d.cls = s2_cls_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s3_pass_q  <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= !dq_empty_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s3_pass_q  <= s2_pass_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_px_q    <= $signed(dq_data_i.gx) * mw;
      s1_py_q    <= $signed(dq_data_i.gy) * mh;
      s1_pw_q    <= $signed(dq_data_i.gw) * mw;
      s1_ph_q    <= $signed(dq_data_i.gh) * mh;
      s1_score_q <= $signed(dq_data_i.best) * $signed(dq_data_i.obj);
      s1_best_q  <= dq_data_i.best;
      s1_cls_q   <= dq_data_i.cls;
      s2_dx_q    <= dx_d;
      s2_dy_q    <= dy_d;
      s2_limw_q  <= DW'(s1_pw_q) >= limx;
      s2_limh_q  <= DW'(s1_ph_q) >= limy;
      s2_tw_q    <= tw_d;
      s2_th_q    <= th_d;
      s2_conf_q  <= conf_d;
      s2_pass_q  <= pass_d;
      s2_cls_q   <= s1_cls_q;
      s3_res_q   <= res_d;
    end
  end

endmodule

[rtl/detection_box_decode.sv]
// Top level of the detection box decoder: configuration, row front end, box back end.
//
//  channel | ports                                       | transaction when
//  --------+---------------------------------------------+--------------------------
//  input   | push, full, value_i                         | push && !full
//  result  | empty, pop, left_o .. class_id_o            | pop && !empty
//  config  | cfg_we_i, cfg_addr_i, cfg_wdata_i           | cfg_we_i
//
// One row element is taken every cycle while full is low. A row's box, when it
// passes the threshold, reaches the result ports through a row queue, three
// arithmetic stages and a two-entry result queue.
// Reset leaves the row position at zero and both queues empty.
// A stalled result side backs up the arithmetic stages and then the row queue; full
// rises only when the last class score of a row meets a full row queue.
module detection_box_decode #(
  parameter int MAX_CLASSES = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [dbd_pkg::VALUE_W-1:0]  value_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [dbd_pkg::PIX_W-1:0]           left_o,
  output logic [dbd_pkg::PIX_W-1:0]           top_o,
  output logic signed [dbd_pkg::PIX_W-1:0]    box_width_o,
  output logic signed [dbd_pkg::PIX_W-1:0]    box_height_o,
  output logic signed [dbd_pkg::VALUE_W-1:0]  confidence_o,
  output logic [dbd_pkg::CLASS_W-1:0]         class_id_o,
  input  logic                                cfg_we_i,
  input  logic [dbd_pkg::CFG_AW-1:0]          cfg_addr_i,
  input  logic [dbd_pkg::CFG_DW-1:0]          cfg_wdata_i
);

  localparam int DESC_W = $bits(dbd_pkg::desc_t);
  localparam int RES_W  = $bits(dbd_pkg::res_t);

  dbd_pkg::cfg_t  cfg_q;
  dbd_pkg::desc_t dq_in, dq_out;
  dbd_pkg::res_t  of_in, of_out;
  logic           dq_push, dq_full, dq_pop, dq_empty;
  logic           of_push, of_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= 1'b0;
      cfg_q.scaled <= 1'b0;
      cfg_q.thr    <= dbd_pkg::THR_RESET;
      cfg_q.img_w  <= dbd_pkg::IMG_W_RESET;
      cfg_q.img_h  <= dbd_pkg::IMG_H_RESET;
      cfg_q.count  <= dbd_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        dbd_pkg::REG_MODE:   cfg_q.mode   <= cfg_wdata_i[0];
        dbd_pkg::REG_SCALED: cfg_q.scaled <= cfg_wdata_i[0];
        dbd_pkg::REG_THR:    cfg_q.thr    <= cfg_wdata_i[dbd_pkg::THR_W-1:0];
        dbd_pkg::REG_IMG_W:  cfg_q.img_w  <= cfg_wdata_i[dbd_pkg::IMG_W-1:0];
        dbd_pkg::REG_IMG_H:  cfg_q.img_h  <= cfg_wdata_i[dbd_pkg::IMG_W-1:0];
        dbd_pkg::REG_COUNT:  cfg_q.count  <= cfg_wdata_i[dbd_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  dbd_front #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .push_i    (push),
    .value_i   (value_i),
    .full_o    (full),
    .dq_full_i (dq_full),
    .dq_push_o (dq_push),
    .dq_data_o (dq_in)
  );

  dbd_fifo #(
    .WIDTH(DESC_W),
    .DEPTH(2)
  ) u_row_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (dq_push),
    .data_i  (dq_in),
    .full_o  (dq_full),
    .pop_i   (dq_pop),
    .data_o  (dq_out),
    .empty_o (dq_empty)
  );

  dbd_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .dq_empty_i (dq_empty),
    .dq_data_i  (dq_out),
    .dq_pop_o   (dq_pop),
    .of_full_i  (of_full),
    .of_push_o  (of_push),
    .of_data_o  (of_in)
  );

  dbd_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (of_push),
    .data_i  (of_in),
    .full_o  (of_full),
    .pop_i   (pop),
    .data_o  (of_out),
    .empty_o (empty)
  );

  assign left_o        = of_out.left;
  assign top_o         = of_out.top;
  assign box_width_o   = $signed(of_out.bw);
  assign box_height_o  = $signed(of_out.bh);
  assign confidence_o  = $signed(of_out.conf);
  assign class_id_o    = of_out.cls;

endmodule
